// ===== rtl/core/bsud_pkg.sv =====
// Shared encodings, constants and queue entry type of the BOM-sniffing decoder.
package bsud_pkg;

	// Encoding in use, as reported on the result side
	localparam logic [2:0] ENC_UTF8    = 3'd0;
	localparam logic [2:0] ENC_UTF16LE = 3'd1;
	localparam logic [2:0] ENC_UTF16BE = 3'd2;
	localparam logic [2:0] ENC_UTF32LE = 3'd3;
	localparam logic [2:0] ENC_UTF32BE = 3'd4;

	// Forced encoding register codes (one above the encoding in use)
	localparam logic [2:0] FORCE_NONE     = 3'd0;
	localparam logic [2:0] FORCE_UTF32BE  = 3'd5;

	// Configuration register indexes
	localparam logic CFG_SNIFF_ENABLE = 1'b0;
	localparam logic CFG_FORCED_ENC   = 1'b1;

	localparam logic [20:0] REPL_CP = 21'h00FFFD;
	localparam logic [31:0] MAX_CP  = 32'h0010FFFF;

	// One byte handed from the front to the decoder
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] enc;
		logic       eos;       // last byte of the file: flush decoder state
		logic       step_end;  // last byte caused by one input item
	} bsud_entry_t;

endpackage

// ===== rtl/core/bsud_fifo.sv =====
// Small queue of decoder entries between the front and the back.
module bsud_fifo import bsud_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bsud_entry_t din,
	output logic        full,
	output logic        valid,
	input  logic        pop,
	output bsud_entry_t dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bsud_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == FULL_CNT);
	assign valid = (cnt_q != '0);
	assign dout  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/bsud_front.sv =====
// Front: takes file bytes, sniffs the byte order mark and queues bytes to decode.
module bsud_front import bsud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_wdata,
	output logic        q_push,
	output bsud_entry_t q_din,
	input  logic        q_full
);

	logic       sniff_en_q;
	logic [2:0] forced_q;
	logic [7:0] sb_q [4];
	logic [1:0] sc_q;
	logic       sdone_q;
	logic [2:0] enc_q;
	logic       rp_act_q;
	logic [1:0] rp_idx_q;
	logic [1:0] rp_last_q;
	logic       rp_eos_q;

	logic       accept;
	logic       direct;
	logic       finish;
	logic [7:0] cand [4];
	logic [2:0] n;
	logic [2:0] det, det_fin, skip;
	logic       rp_at_last;

	assign s_tready   = !rp_act_q && !q_full;
	assign accept     = s_tvalid && s_tready;
	assign direct     = sdone_q || !sniff_en_q;
	assign finish     = !direct && ((sc_q == 2'd3) || s_tlast);
	assign n          = {1'b0, sc_q} + 3'd1;
	assign rp_at_last = (rp_idx_q == rp_last_q);

	// bytes seen so far including the one on the port
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cand[i] = (sc_q == 2'(i)) ? s_tdata : sb_q[i];
		end
	end

	// mark match in priority order, then the forced override
	always_comb begin
		det  = ENC_UTF8;
		skip = 3'd0;
		if (n >= 3'd4 && cand[0] == 8'h00 && cand[1] == 8'h00 &&
		    cand[2] == 8'hFE && cand[3] == 8'hFF) begin
			det  = ENC_UTF32BE;
			skip = 3'd4;
		end else if (n >= 3'd4 && cand[0] == 8'hFF && cand[1] == 8'hFE &&
		             cand[2] == 8'h00 && cand[3] == 8'h00) begin
			det  = ENC_UTF32LE;
			skip = 3'd4;
		end else if (n >= 3'd3 && cand[0] == 8'hEF && cand[1] == 8'hBB &&
		             cand[2] == 8'hBF) begin
			det  = ENC_UTF8;
			skip = 3'd3;
		end else if (n >= 3'd2 && cand[0] == 8'hFE && cand[1] == 8'hFF) begin
			det  = ENC_UTF16BE;
			skip = 3'd2;
		end else if (n >= 3'd2 && cand[0] == 8'hFF && cand[1] == 8'hFE) begin
			det  = ENC_UTF16LE;
			skip = 3'd2;
		end
		if (forced_q != FORCE_NONE && forced_q <= FORCE_UTF32BE) begin
			det_fin = forced_q - 3'd1;
		end else begin
			det_fin = det;
		end
	end

	// queue write: replayed bytes, or a byte that goes straight through
	always_comb begin
		q_push = 1'b0;
		q_din  = '0;
		if (rp_act_q) begin
			q_push         = !q_full;
			q_din.data     = sb_q[rp_idx_q];
			q_din.enc      = enc_q;
			q_din.eos      = rp_eos_q && rp_at_last;
			q_din.step_end = rp_at_last;
		end else if (accept && direct) begin
			q_push         = 1'b1;
			q_din.data     = s_tdata;
			q_din.enc      = sdone_q ? enc_q : ENC_UTF8;
			q_din.eos      = s_tlast;
			q_din.step_end = 1'b1;
		end
	end

	// sniff buffer
	always_ff @(posedge clk) begin
		if (accept && !direct) begin
			sb_q[sc_q] <= s_tdata;
		end
	end

	// configuration, sniff control and replay sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sniff_en_q <= 1'b1;
			forced_q   <= FORCE_NONE;
			sc_q       <= '0;
			sdone_q    <= 1'b0;
			enc_q      <= ENC_UTF8;
			rp_act_q   <= 1'b0;
			rp_idx_q   <= '0;
			rp_last_q  <= '0;
			rp_eos_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SNIFF_ENABLE: sniff_en_q <= cfg_wdata[0];
					CFG_FORCED_ENC:   forced_q   <= cfg_wdata;
					default:          ;
				endcase
			end

			if (accept) begin
				if (!sdone_q && !sniff_en_q) begin
					// sniffing off: the file is raw bytes
					sdone_q <= !s_tlast;
					enc_q   <= ENC_UTF8;
				end else if (!sdone_q) begin
					if (finish) begin
						sc_q <= '0;
						if (skip < n) begin
							sdone_q   <= 1'b1;
							enc_q     <= det_fin;
							rp_act_q  <= 1'b1;
							rp_idx_q  <= skip[1:0];
							rp_last_q <= sc_q;
							rp_eos_q  <= s_tlast;
						end else if (s_tlast) begin
							sdone_q <= 1'b0;
							enc_q   <= ENC_UTF8;
						end else begin
							sdone_q <= 1'b1;
							enc_q   <= det_fin;
						end
					end else begin
						sc_q <= sc_q + 2'd1;
					end
				end else if (s_tlast) begin
					sdone_q <= 1'b0;
					enc_q   <= ENC_UTF8;
				end
			end

			if (rp_act_q && !q_full) begin
				rp_idx_q <= rp_idx_q + 2'd1;
				if (rp_at_last) begin
					rp_act_q <= 1'b0;
					if (rp_eos_q) begin
						sdone_q <= 1'b0;
						enc_q   <= ENC_UTF8;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/bsud_back.sv =====
// Back: assembles code units, decodes code points and drives the result channel.
module bsud_back import bsud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  bsud_entry_t q_dout,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	output logic [3:0]  m_tuser
);

	// a result, or a bare marker that closes the run of an item
	typedef struct packed {
		logic        marker;
		logic [20:0] value;
		logic        raw;
		logic [2:0]  enc;
		logic        close;
	} tok_t;

	// decoder state
	logic [23:0] ub_q;
	logic [1:0]  ucnt_q;
	logic [9:0]  ph_q;
	logic        pv_q;

	// results of the last decoded entry
	tok_t        tk_q [2];
	logic [1:0]  rem_q;
	logic        head_q;

	// hold stage (last flag not yet known) and output register
	logic        h_v_q;
	tok_t        h_q;
	logic        o_v_q;
	tok_t        o_q;

	logic [23:0] nb_ub;
	logic [1:0]  nb_ucnt;
	logic [9:0]  nb_ph;
	logic        nb_pv;
	tok_t        r [2];
	logic [1:0]  rn;
	logic [1:0]  need_last;
	logic [15:0] u16;
	logic [31:0] u32;
	logic        is_hi, is_lo;

	logic        tok_avail;
	tok_t        cur;
	logic        o_free;
	logic        h_move;
	logic        tok_take;

	function automatic tok_t mk_tok(logic [20:0] v, logic raw, logic [2:0] enc);
		tok_t t;
		t        = '0;
		t.value  = v;
		t.raw    = raw;
		t.enc    = enc;
		return t;
	endfunction

	// decode one queued byte into at most two results
	always_comb begin
		nb_ub     = ub_q;
		nb_ucnt   = ucnt_q;
		nb_ph     = ph_q;
		nb_pv     = pv_q;
		r[0]      = '0;
		r[1]      = '0;
		rn        = 2'd0;
		u16       = '0;
		u32       = '0;
		is_hi     = 1'b0;
		is_lo     = 1'b0;
		need_last = (q_dout.enc == ENC_UTF16LE || q_dout.enc == ENC_UTF16BE) ? 2'd1 : 2'd3;

		if (q_dout.enc == ENC_UTF8) begin
			r[0] = mk_tok({13'd0, q_dout.data}, 1'b1, q_dout.enc);
			rn   = 2'd1;
		end else if (ucnt_q != need_last) begin
			nb_ub   = ub_q | ({16'd0, q_dout.data} << {ucnt_q, 3'd0});
			nb_ucnt = ucnt_q + 2'd1;
		end else begin
			nb_ub   = '0;
			nb_ucnt = '0;
			if (need_last == 2'd1) begin
				u16   = (q_dout.enc == ENC_UTF16LE) ? {q_dout.data, ub_q[7:0]}
				                                    : {ub_q[7:0], q_dout.data};
				is_hi = (u16[15:10] == 6'b110110);
				is_lo = (u16[15:10] == 6'b110111);
				if (pv_q && is_lo) begin
					// complete surrogate pair
					nb_pv = 1'b0;
					r[0]  = mk_tok(21'h010000 + {1'b0, ph_q, u16[9:0]}, 1'b0, q_dout.enc);
					rn    = 2'd1;
				end else begin
					if (pv_q) begin
						// high surrogate not followed by a low one
						nb_pv = 1'b0;
						r[0]  = mk_tok(REPL_CP, 1'b0, q_dout.enc);
						rn    = 2'd1;
					end
					if (is_hi) begin
						nb_ph = u16[9:0];
						nb_pv = 1'b1;
					end else begin
						r[rn[0]] = mk_tok(is_lo ? REPL_CP : {5'd0, u16}, 1'b0, q_dout.enc);
						rn       = rn + 2'd1;
					end
				end
			end else begin
				u32 = (q_dout.enc == ENC_UTF32LE)
				    ? {q_dout.data, ub_q[23:16], ub_q[15:8], ub_q[7:0]}
				    : {ub_q[7:0], ub_q[15:8], ub_q[23:16], q_dout.data};
				if (u32 > MAX_CP || u32[31:11] == 21'h00001B) begin
					r[0] = mk_tok(REPL_CP, 1'b0, q_dout.enc);
				end else begin
					r[0] = mk_tok(u32[20:0], 1'b0, q_dout.enc);
				end
				rn = 2'd1;
			end
		end

		// end of file: dangling high surrogate, then flush
		if (q_dout.eos) begin
			if (nb_pv) begin
				r[rn[0]] = mk_tok(REPL_CP, 1'b0, q_dout.enc);
				rn       = rn + 2'd1;
			end
			nb_ub   = '0;
			nb_ucnt = '0;
			nb_ph   = '0;
			nb_pv   = 1'b0;
		end

		// mark the final result of the item, or leave a marker
		if (q_dout.step_end) begin
			if (rn == 2'd0) begin
				r[0].marker = 1'b1;
				r[0].close  = 1'b1;
				rn          = 2'd1;
			end else begin
				r[rn[0] - 1'b1].close = 1'b1;
			end
		end
	end

	// result flow: decoded slot -> hold -> output register
	assign tok_avail = (rem_q != 2'd0);
	assign cur       = tk_q[head_q];
	assign o_free    = !o_v_q || m_tready;
	assign h_move    = h_v_q && o_free && (h_q.close || (tok_avail && !cur.marker));
	assign tok_take  = tok_avail && (cur.marker || !h_v_q || h_move);
	assign q_pop     = q_valid && ((rem_q == 2'd0) || (rem_q == 2'd1 && tok_take));

	assign m_tvalid = o_v_q;
	assign m_tdata  = {3'd0, o_q.value};
	assign m_tlast  = o_q.close;
	assign m_tuser  = {o_q.enc, o_q.raw};

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			tk_q[0] <= r[0];
			tk_q[1] <= r[1];
		end
		if (tok_take && !cur.marker) begin
			h_q <= cur;
		end else if (tok_take && h_v_q && !h_q.close) begin
			h_q.close <= 1'b1;
		end
		if (h_move) begin
			o_q <= h_q;
		end
	end

	// decoder state and flow control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ub_q   <= '0;
			ucnt_q <= '0;
			ph_q   <= '0;
			pv_q   <= 1'b0;
			rem_q  <= '0;
			head_q <= 1'b0;
			h_v_q  <= 1'b0;
			o_v_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				ub_q   <= nb_ub;
				ucnt_q <= nb_ucnt;
				ph_q   <= nb_ph;
				pv_q   <= nb_pv;
				rem_q  <= rn;
				head_q <= 1'b0;
			end else if (tok_take) begin
				rem_q  <= rem_q - 2'd1;
				head_q <= head_q + 1'b1;
			end

			if (tok_take && !cur.marker) begin
				h_v_q <= 1'b1;
			end else if (h_move) begin
				h_v_q <= 1'b0;
			end

			if (h_move) begin
				o_v_q <= 1'b1;
			end else if (m_tready) begin
				o_v_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/bom_sniffing_utf16_utf32_decoder.sv =====
// Top level of the BOM-sniffing UTF-8/16/32 byte stream decoder.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid / tready    tdata = data_byte, tlast = end_of_stream
//  m_*       out  tvalid / tready    tdata = value, tlast = last_of_run,
//                                    tuser = raw_byte, active_encoding
//  cfg_*     in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
//  One byte per cycle is taken while the queue has room and no replay runs. When
//  sniffing ends (fourth byte of a file, or an earlier end of stream) the buffered
//  bytes outside the mark are replayed into the queue, one per cycle while it has
//  room, with s_tready low until the replay ends. The decoder yields one result
//  per cycle while the output is not stalled; a byte that gives two results holds off
//  the next queue read until both have gone, absorbed by the QUEUE_DEPTH-entry queue.
//  Asynchronous reset: sniffing enabled, no forced encoding, stream state cleared.
module bom_sniffing_utf16_utf32_decoder import bsud_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] value, [23:21] zero
	output logic        m_tlast,
	output logic [3:0]  m_tuser,   // [0] raw_byte, [3:1] active_encoding
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_wdata
);

	logic        q_push, q_full, q_valid, q_pop;
	bsud_entry_t q_din, q_dout;

	bsud_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_push    (q_push),
		.q_din     (q_din),
		.q_full    (q_full)
	);

	bsud_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (q_pop),
		.dout   (q_dout)
	);

	bsud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_dout   (q_dout),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
